// ===== rtl/core/tcca_pkg.sv =====
// Shared types and constants of the two-class crossing arbiter.
package tcca_pkg;

   localparam int ACTION_W = 3;
   localparam int IDENT_W  = 16;
   localparam int STAMP_W  = 32;
   localparam int STATUS_W = 2;
   localparam int RESULT_W = 16;
   localparam int CSR_W    = 32;

   localparam logic [CSR_W-1:0] RESET_TIME_DEFAULT = 32'd10000;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CROSS_ENTER = 3'd0,
      ACT_CROSS_EXIT  = 3'd1,
      ACT_CROSS_WAIT  = 3'd2,
      ACT_DONE_WAIT   = 3'd3,
      ACT_VEH_ENTER   = 3'd4,
      ACT_VEH_EXIT    = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_DO_NOT_ENTER = 2'd1,
      ST_EXIT_ERROR   = 2'd2,
      ST_FULL         = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_SCAN,
      FSM_DONE
   } fsm_type;

   typedef enum logic [1:0] {
      SEL_CROSS,
      SEL_VEH,
      SEL_WAIT
   } set_sel_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

   typedef struct packed {
      logic clear;
      logic grant;
      logic step;
      logic drop;
   } set_ctl_type;

endpackage

// ===== rtl/core/tcca_channels.sv =====
// Handshake channel interfaces: request, response and register write.
interface tcca_req_if import tcca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [IDENT_W-1:0]  ident;
   logic [STAMP_W-1:0]  timestamp;

   modport source (output valid, action, ident, timestamp, input ready);
   modport sink   (input valid, action, ident, timestamp, output ready);
endinterface

interface tcca_rsp_if import tcca_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [RESULT_W-1:0] result_id;

   modport source (output valid, status, result_id, input ready);
   modport sink   (input valid, status, result_id, output ready);
endinterface

interface tcca_csr_if import tcca_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] wdata;

   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

// ===== rtl/core/two_class_crossing_arbiter.sv =====
// Two-class crossing arbiter. Crossers and vehicles share one crossing under
// mutual exclusion; waiting crossers block vehicles. Each set is a row of
// SET_DEPTH id cells in arrival order. Each item is accepted, executed and
// its result handed to the output register before the next acceptance;
// exit and done-waiting on a non-empty set also scan the addressed set
// between execute and hand-over: the row rotates one cell per cycle past
// the head comparator, dropping the oldest match, and comes back in its
// original order. A new item is taken while the previous result still waits
// in the output register. reset_time (reset value 10000 ticks) must be
// written through the csr channel only while idle; the block does not enforce it.
module two_class_crossing_arbiter import tcca_pkg::*; #(
   parameter int SET_DEPTH  = 16,
   parameter int ID_WIDTH   = 16,
   parameter int TIME_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   tcca_csr_if.sink    csr_chan,
   tcca_req_if.sink    req_chan,
   tcca_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(SET_DEPTH + 1);
   localparam int CMP_W = (TIME_WIDTH > CSR_W) ? TIME_WIDTH : CSR_W;

   // control
   fsm_type          state_ff,  state_in;
   set_sel_type      sel_ff,    sel_in;
   logic [CNT_W-1:0] steps_ff,  steps_in;
   logic             found_ff,  found_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // configuration and bookkeeping
   logic [CSR_W-1:0]      reset_time_ff;
   logic [TIME_WIDTH-1:0] last_act_ff,  last_act_in;
   logic [ID_WIDTH-1:0]   cnt_cross_ff, cnt_cross_in;
   logic [ID_WIDTH-1:0]   cnt_veh_ff,   cnt_veh_in;
   logic [ID_WIDTH-1:0]   cnt_wait_ff,  cnt_wait_in;

   // latched item and results
   logic [ACTION_W-1:0]   act_ff,   act_in;
   logic [ID_WIDTH-1:0]   ident_ff, ident_in;
   logic [TIME_WIDTH-1:0] stamp_ff, stamp_in;
   status_type            res_status_ff, res_status_in;
   logic [ID_WIDTH-1:0]   res_id_ff,     res_id_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ID_WIDTH-1:0]   rsp_id_ff,     rsp_id_in;

   // set rows
   set_ctl_type         ctl_cross, ctl_veh, ctl_wait;
   logic [CNT_W-1:0]    n_cross, n_veh, n_wait;
   logic [ID_WIDTH-1:0] head_cross, head_veh, head_wait;
   logic [ID_WIDTH-1:0] next_cross, next_veh, next_wait;

   logic [ID_WIDTH-1:0]   sel_head;
   logic [TIME_WIDTH-1:0] idle_span;
   logic                  inactive;
   logic                  hit;
   logic                  found_now;

   // Counters restart at 1 whenever their set is empty.
   assign next_cross = ((n_cross == '0) ? '0 : cnt_cross_ff) + ID_WIDTH'(1);
   assign next_veh   = ((n_veh   == '0) ? '0 : cnt_veh_ff)   + ID_WIDTH'(1);
   assign next_wait  = ((n_wait  == '0) ? '0 : cnt_wait_ff)  + ID_WIDTH'(1);

   assign idle_span = stamp_ff - last_act_ff;
   assign inactive  = CMP_W'(idle_span) >= CMP_W'(reset_time_ff);

   tcca_set #(.DEPTH(SET_DEPTH), .ID_W(ID_WIDTH)) u_cross (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_cross),
      .grant_id (next_cross),
      .count    (n_cross),
      .head_id  (head_cross)
   );

   tcca_set #(.DEPTH(SET_DEPTH), .ID_W(ID_WIDTH)) u_veh (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_veh),
      .grant_id (next_veh),
      .count    (n_veh),
      .head_id  (head_veh)
   );

   tcca_set #(.DEPTH(SET_DEPTH), .ID_W(ID_WIDTH)) u_wait (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl_wait),
      .grant_id (next_wait),
      .count    (n_wait),
      .head_id  (head_wait)
   );

   // set addressed by a removal
   always_comb begin
      unique case (sel_ff)
         SEL_CROSS: begin
            sel_head  = head_cross;
         end
         SEL_VEH: begin
            sel_head  = head_veh;
         end
         SEL_WAIT: begin
            sel_head  = head_wait;
         end
         default: begin
            sel_head  = '0;
         end
      endcase
   end

   assign hit       = !found_ff && (sel_head == ident_ff);
   assign found_now = found_ff || hit;

   always_comb begin
      state_in      = state_ff;
      sel_in        = sel_ff;
      steps_in      = steps_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff;
      last_act_in   = last_act_ff;
      cnt_cross_in  = cnt_cross_ff;
      cnt_veh_in    = cnt_veh_ff;
      cnt_wait_in   = cnt_wait_ff;
      act_in        = act_ff;
      ident_in      = ident_ff;
      stamp_in      = stamp_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      ctl_cross     = '0;
      ctl_veh       = '0;
      ctl_wait      = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         FSM_IDLE: begin
            if (req_chan.valid) begin
               act_in   = req_chan.action;
               ident_in = ID_WIDTH'(req_chan.ident);
               stamp_in = TIME_WIDTH'(req_chan.timestamp);
               state_in = FSM_EXEC;
            end
         end

         FSM_EXEC: begin
            res_status_in = ST_DO_NOT_ENTER;
            res_id_in     = '0;
            state_in      = FSM_DONE;
            unique case (action_type'(act_ff))
               ACT_CROSS_ENTER: begin
                  if (n_veh == '0) begin
                     if (n_cross == CNT_W'(SET_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ctl_cross.grant = 1'b1;
                        cnt_cross_in    = next_cross;
                        res_status_in   = ST_OK;
                        res_id_in       = next_cross;
                        last_act_in     = stamp_ff;
                     end
                  end
               end
               ACT_VEH_ENTER: begin
                  if (n_cross == '0 && n_wait == '0) begin
                     if (n_veh == CNT_W'(SET_DEPTH)) begin
                        res_status_in = ST_FULL;
                     end else begin
                        ctl_veh.grant = 1'b1;
                        cnt_veh_in    = next_veh;
                        res_status_in = ST_OK;
                        res_id_in     = next_veh;
                        last_act_in   = stamp_ff;
                     end
                  end
               end
               ACT_CROSS_WAIT: begin
                  // stale crossing: flush crossers and vehicles first
                  if (inactive) begin
                     ctl_cross.clear = 1'b1;
                     ctl_veh.clear   = 1'b1;
                     cnt_cross_in    = '0;
                     cnt_veh_in      = '0;
                  end
                  if (n_wait == CNT_W'(SET_DEPTH)) begin
                     res_status_in = ST_FULL;
                  end else begin
                     ctl_wait.grant = 1'b1;
                     cnt_wait_in    = next_wait;
                     res_status_in  = ST_OK;
                     res_id_in      = next_wait;
                  end
               end
               ACT_CROSS_EXIT, ACT_DONE_WAIT, ACT_VEH_EXIT: begin
                  last_act_in = stamp_ff;
                  found_in    = 1'b0;
                  unique case (action_type'(act_ff))
                     ACT_CROSS_EXIT: begin
                        sel_in   = SEL_CROSS;
                        steps_in = n_cross;
                     end
                     ACT_VEH_EXIT: begin
                        sel_in   = SEL_VEH;
                        steps_in = n_veh;
                     end
                     default: begin
                        sel_in   = SEL_WAIT;
                        steps_in = n_wait;
                     end
                  endcase
                  res_status_in = ST_EXIT_ERROR;
                  if (steps_in != '0) begin
                     state_in = FSM_SCAN;
                  end
               end
               default: begin
                  res_status_in = ST_DO_NOT_ENTER;
               end
            endcase
         end

         FSM_SCAN: begin
            // one rotation step per cycle, oldest match dropped
            unique case (sel_ff)
               SEL_CROSS: begin
                  ctl_cross.step = 1'b1;
                  ctl_cross.drop = hit;
               end
               SEL_VEH: begin
                  ctl_veh.step = 1'b1;
                  ctl_veh.drop = hit;
               end
               default: begin
                  ctl_wait.step = 1'b1;
                  ctl_wait.drop = hit;
               end
            endcase
            found_in = found_now;
            steps_in = steps_ff - CNT_W'(1);
            if (steps_ff == CNT_W'(1)) begin
               state_in = FSM_DONE;
               if (found_now) begin
                  res_status_in = ST_OK;
                  res_id_in     = ident_ff;
               end else begin
                  res_status_in = ST_EXIT_ERROR;
                  res_id_in     = '0;
               end
            end
         end

         FSM_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_id_in     = res_id_ff;
               state_in      = FSM_IDLE;
            end
         end

         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_IDLE;
         sel_ff        <= SEL_CROSS;
         steps_ff      <= '0;
         found_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         reset_time_ff <= RESET_TIME_DEFAULT;
         last_act_ff   <= '0;
         cnt_cross_ff  <= '0;
         cnt_veh_ff    <= '0;
         cnt_wait_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         steps_ff     <= steps_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         last_act_ff  <= last_act_in;
         cnt_cross_ff <= cnt_cross_in;
         cnt_veh_ff   <= cnt_veh_in;
         cnt_wait_ff  <= cnt_wait_in;
         if (csr_chan.valid) begin
            reset_time_ff <= csr_chan.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      ident_ff      <= ident_in;
      stamp_ff      <= stamp_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign csr_chan.ready     = 1'b1;
   assign req_chan.ready     = (state_ff == FSM_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.status    = rsp_status_ff;
   assign rsp_chan.result_id = RESULT_W'(rsp_id_ff);

endmodule

// ===== rtl/core/tcca_cell.sv =====
// One id cell of a set row: loads a new id or takes its right neighbor's.
module tcca_cell import tcca_pkg::*; #(
   parameter int ID_W = 16
) (
   input  logic            clock,
   input  cell_ctl_type    ctl,
   input  logic [ID_W-1:0] load_id,
   input  logic [ID_W-1:0] right_id,
   output logic [ID_W-1:0] id
);

   logic [ID_W-1:0] id_ff;
   logic [ID_W-1:0] id_in;

   always_comb begin
      id_in = id_ff;
      priority if (ctl.load) begin
         id_in = load_id;
      end else if (ctl.shift) begin
         id_in = right_id;
      end
   end

   always_ff @(posedge clock) begin
      id_ff <= id_in;
   end

   assign id = id_ff;

endmodule

// ===== rtl/core/tcca_set.sv =====
// One id set: a row of cells kept in arrival order plus its fill count.
module tcca_set import tcca_pkg::*; #(
   parameter  int DEPTH = 16,
   parameter  int ID_W  = 16,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  set_ctl_type      ctl,
   input  logic [ID_W-1:0]  grant_id,
   output logic [CNT_W-1:0] count,
   output logic [ID_W-1:0]  head_id
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic [ID_W-1:0]  cell_id [DEPTH];
   logic [ID_W-1:0]  load_id;

   // A step pops the head; it is re-inserted at the tail unless dropped.
   assign load_id = ctl.grant ? grant_id : cell_id[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [ID_W-1:0] right_id;
      cell_ctl_type    cctl;

      if (i == DEPTH - 1) begin : g_last
         assign right_id = cell_id[i];
      end else begin : g_mid
         assign right_id = cell_id[i+1];
      end

      assign cctl.shift = ctl.step;
      assign cctl.load  = (ctl.grant && (count_ff == CNT_W'(i)))
                       || (ctl.step && !ctl.drop && (count_ff == CNT_W'(i + 1)));

      tcca_cell #(.ID_W(ID_W)) u_cell (
         .clock    (clock),
         .ctl      (cctl),
         .load_id  (load_id),
         .right_id (right_id),
         .id       (cell_id[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      priority if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.grant) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.step && ctl.drop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign count   = count_ff;
   assign head_id = cell_id[0];

endmodule
